/* rtl/core/nrsc_pkg.sv */
package nrsc_pkg;

  localparam int CACHE_DEPTH = 128;
  localparam int PTR_W       = $clog2(CACHE_DEPTH);
  localparam int CNT_W       = $clog2(CACHE_DEPTH + 1);
  localparam int SEQ_W       = 16;
  localparam int MASK_W      = 16;
  localparam int VER_W       = 2;
  localparam int CFG_W       = 8;
  localparam int SLOT_W      = 7;
  localparam int LIM_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = CFG_W'(100);
  localparam logic [VER_W-1:0] STORED_VERSION  = VER_W'(2);
  localparam logic             FUNC_RECORD     = 1'b0;
  localparam logic             FUNC_NACK       = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic record;     // store in_seq_num in the ring
    logic load_nack;  // latch NACK id and mask
    logic step;       // move to next mask bit
    logic scan;       // ring search in progress
    logic emit;       // load the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bit0;       // current mask bit is set
    logic last;       // current lookup is the final one
    logic scan_done;
    logic out_busy;
  } sts_t;

  // ptr + off modulo depth, ptr < depth and off <= depth
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(ptr) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(CACHE_DEPTH)) begin
      s = s - (CNT_W+1)'(CACHE_DEPTH);
    end
    return PTR_W'(s);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_bits(input logic [PTR_W-1:0] ptr);
    return SLOT_W'({{SLOT_W{1'b0}}, ptr});
  endfunction

endpackage

/* rtl/core/nrsc_ctrl.sv */
module nrsc_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_func,
  input  logic [nrsc_pkg::VER_W-1:0]      in_rtp_version,
  output logic                            in_ready,
  input  nrsc_pkg::sts_t                  sts,
  output nrsc_pkg::cmd_t                  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_EMIT = 4'b0100,
    ST_NEXT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == nrsc_pkg::FUNC_NACK) begin
            cmd.load_nack = 1'b1;
            state_nxt     = ST_SCAN;
          end else begin
            cmd.record = (in_rtp_version == nrsc_pkg::STORED_VERSION);
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last ? ST_IDLE : ST_NEXT;
        end
      end
      ST_NEXT: begin
        cmd.step = 1'b1;
        if (sts.bit0) state_nxt = ST_SCAN;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/nrsc_dp.sv */
module nrsc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  nrsc_pkg::cmd_t                    cmd,
  output nrsc_pkg::sts_t                    sts,
  input  logic [nrsc_pkg::SEQ_W-1:0]        in_seq_num,
  input  logic [nrsc_pkg::MASK_W-1:0]       in_lost_mask,
  input  logic                              cfg_valid,
  input  logic [nrsc_pkg::CFG_W-1:0]        cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [nrsc_pkg::SEQ_W-1:0]        out_req_seq,
  output logic                              out_found,
  output logic [nrsc_pkg::SLOT_W-1:0]       out_slot,
  output logic                              out_last
);

  logic [nrsc_pkg::SEQ_W-1:0]  mem [nrsc_pkg::CACHE_DEPTH];

  logic [nrsc_pkg::CFG_W-1:0]  max_entries_r;
  logic [nrsc_pkg::PTR_W-1:0]  oldest_r, oldest_nxt;
  logic [nrsc_pkg::CNT_W-1:0]  count_r, count_nxt;

  logic [nrsc_pkg::SEQ_W-1:0]  tgt_r;
  logic [nrsc_pkg::MASK_W-1:0] rem_r;
  logic                        last_r;
  logic [nrsc_pkg::CNT_W-1:0]  issue_idx_r;
  logic                        pend_r;
  logic [nrsc_pkg::SEQ_W-1:0]  rd_data_r;
  logic [nrsc_pkg::PTR_W-1:0]  rd_slot_r;
  logic                        res_found_r;
  logic [nrsc_pkg::SLOT_W-1:0] res_slot_r;

  logic                        out_valid_r;
  logic [nrsc_pkg::SEQ_W-1:0]  out_req_seq_r;
  logic                        out_found_r;
  logic [nrsc_pkg::SLOT_W-1:0] out_slot_r;
  logic                        out_last_r;

  logic [nrsc_pkg::LIM_W-1:0]  max_ext, lim_w, count_ext;
  logic                        at_limit;
  logic [nrsc_pkg::PTR_W-1:0]  wr_addr, rd_addr;
  logic                        rd_en, match_now, scan_done;
  logic [nrsc_pkg::MASK_W-1:0] rem_shift;

  // effective limit: 0 acts as 1, clamp at ring depth
  always_comb begin
    max_ext   = nrsc_pkg::LIM_W'(max_entries_r);
    count_ext = nrsc_pkg::LIM_W'(count_r);
    if (max_ext == '0) begin
      lim_w = nrsc_pkg::LIM_W'(1);
    end else if (max_ext > nrsc_pkg::LIM_W'(nrsc_pkg::CACHE_DEPTH)) begin
      lim_w = nrsc_pkg::LIM_W'(nrsc_pkg::CACHE_DEPTH);
    end else begin
      lim_w = max_ext;
    end
    at_limit = (count_ext >= lim_w);
  end

  // evict-then-append lands on oldest + count either way
  assign wr_addr = nrsc_pkg::ring_add(oldest_r, count_r);

  always_comb begin
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    if (cmd.record) begin
      if (at_limit) begin
        oldest_nxt = nrsc_pkg::ring_add(oldest_r, nrsc_pkg::CNT_W'(1));
      end else begin
        count_nxt = count_r + nrsc_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= nrsc_pkg::MAX_ENTRIES_RST;
      oldest_r      <= '0;
      count_r       <= '0;
    end else begin
      if (cfg_valid) max_entries_r <= cfg_data;
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
    end
  end

  // search: one ring read issued per cycle, compared in the following cycle
  assign match_now = pend_r && (rd_data_r == tgt_r);
  assign scan_done = match_now || (!pend_r && (issue_idx_r >= count_r));
  assign rd_en     = cmd.scan && !match_now && (issue_idx_r < count_r);
  assign rd_addr   = nrsc_pkg::ring_add(oldest_r, issue_idx_r);
  assign rem_shift = rem_r >> 1;

  always_ff @(posedge clk) begin
    if (cmd.record) mem[wr_addr] <= in_seq_num;
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_slot_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_nack) begin
      tgt_r  <= in_seq_num;
      rem_r  <= in_lost_mask;
      last_r <= (in_lost_mask == '0);
    end else if (cmd.step) begin
      tgt_r  <= tgt_r + nrsc_pkg::SEQ_W'(1);
      rem_r  <= rem_shift;
      last_r <= (rem_shift == '0);
    end
    if (cmd.scan && scan_done) begin
      res_found_r <= match_now;
      res_slot_r  <= match_now ? nrsc_pkg::slot_bits(rd_slot_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_idx_r <= '0;
      pend_r      <= 1'b0;
    end else if (cmd.load_nack || cmd.step) begin
      issue_idx_r <= '0;
      pend_r      <= 1'b0;
    end else begin
      pend_r <= rd_en;
      if (rd_en) issue_idx_r <= issue_idx_r + nrsc_pkg::CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_req_seq_r <= tgt_r;
      out_found_r   <= res_found_r;
      out_slot_r    <= res_slot_r;
      out_last_r    <= last_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_req_seq = out_req_seq_r;
  assign out_found   = out_found_r;
  assign out_slot    = out_slot_r;
  assign out_last    = out_last_r;

  assign sts.bit0      = rem_r[0];
  assign sts.last      = last_r;
  assign sts.scan_done = scan_done;
  assign sts.out_busy  = out_valid_r && !out_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= nrsc_pkg::CNT_W'(nrsc_pkg::CACHE_DEPTH))
    else $error("entry count above ring depth");

  a_full_record_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.record && at_limit |=> count_r == $past(count_r))
    else $error("record at limit changed entry count");

  a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_slot_r == '0)
    else $error("miss result with nonzero slot");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> issue_idx_r <= count_r)
    else $error("search read beyond valid entries");

endmodule

/* rtl/core/nack_retransmit_seq_cache_core.sv */
// NACK retransmission sequence cache. A record request (in_func 0) stores
// in_seq_num in a FIFO ring when in_rtp_version is 2, evicting the oldest entry
// once max_entries (0 acts as 1, clamped to the ring depth) are held. A NACK
// request (in_func 1) gives one result for the id and one for each set bit of
// in_lost_mask (bit 0 = id + 1), out_last on the final one. Each lookup searches
// the ring oldest to newest through the single read port of the ring memory,
// one entry per cycle, stopping at the first hit; the mask is walked one bit at
// a time. No new request is taken while a NACK is in progress. The ring needs no
// clearing after reset. cfg_data writes max_entries and is always taken.
module nack_retransmit_seq_cache_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [nrsc_pkg::SEQ_W-1:0]        in_seq_num,
  input  logic [nrsc_pkg::VER_W-1:0]        in_rtp_version,
  input  logic [nrsc_pkg::MASK_W-1:0]       in_lost_mask,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [nrsc_pkg::SEQ_W-1:0]        out_req_seq,
  output logic                              out_found,
  output logic [nrsc_pkg::SLOT_W-1:0]       out_slot,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nrsc_pkg::CFG_W-1:0]        cfg_data
);

  nrsc_pkg::cmd_t cmd;
  nrsc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  nrsc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_func        (in_func),
    .in_rtp_version (in_rtp_version),
    .in_ready       (in_ready),
    .sts            (sts),
    .cmd            (cmd)
  );

  nrsc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_seq_num   (in_seq_num),
    .in_lost_mask (in_lost_mask),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_req_seq  (out_req_seq),
    .out_found    (out_found),
    .out_slot     (out_slot),
    .out_last     (out_last)
  );

endmodule

/* tb/nack_retransmit_seq_cache_core_tb.sv */
`timescale 1ns / 1ps

module nack_retransmit_seq_cache_core_tb;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int LONG_HOLD       = 300;
  localparam int LONG_HOLD_AFTER = 80;
  localparam int DRAIN_CYCLES    = 20;
  localparam int NUM_PHASES      = 6;
  localparam int NUM_DIRECTED    = 21;

  // limit setting, request count and share of records for each random phase
  localparam int PHASE_LIMIT [NUM_PHASES]      = '{1, 0, 128, 255, 6, 100};
  localparam int PHASE_ITEMS [NUM_PHASES]      = '{30, 30, 100, 60, 30, 20};
  localparam int PHASE_RECORD_PCT [NUM_PHASES] = '{75, 75, 90, 90, 75, 75};

  typedef struct packed {
    logic [nrsc_pkg::SEQ_W-1:0]  req_seq;
    logic                        found;
    logic [nrsc_pkg::SLOT_W-1:0] slot;
    logic                        last;
  } lookup_t;

  typedef struct packed {
    logic                        func;
    logic [nrsc_pkg::SEQ_W-1:0]  seq;
    logic [nrsc_pkg::VER_W-1:0]  ver;
    logic [nrsc_pkg::MASK_W-1:0] mask;
    logic                        typed;
    lookup_t                     want;
  } directed_row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic                        in_func;
  logic [nrsc_pkg::SEQ_W-1:0]  in_seq_num;
  logic [nrsc_pkg::VER_W-1:0]  in_rtp_version;
  logic [nrsc_pkg::MASK_W-1:0] in_lost_mask;
  logic                        out_valid;
  logic                        out_ready;
  logic [nrsc_pkg::SEQ_W-1:0]  out_req_seq;
  logic                        out_found;
  logic [nrsc_pkg::SLOT_W-1:0] out_slot;
  logic                        out_last;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [nrsc_pkg::CFG_W-1:0]  cfg_data;

  // shadow of the sent-sequence ring
  logic [nrsc_pkg::SEQ_W-1:0] sent_seqs [nrsc_pkg::CACHE_DEPTH];
  int unsigned                oldest_slot;
  int unsigned                held_count;
  logic [nrsc_pkg::CFG_W-1:0] keep_limit;
  lookup_t                    lookups_due [$];

  int mismatch_count;
  int results_checked;
  int idle_cycles;
  bit quiet_tail;
  bit tx_bursty;

  // typed rows carry a result that follows directly from the ring contents
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{nrsc_pkg::FUNC_NACK,   16'h0000, 2'd0, 16'h0000, 1'b1, '{16'h0000, 1'b0, 7'd0, 1'b1}},
    '{nrsc_pkg::FUNC_NACK,   16'hFFFF, 2'd3, 16'h0000, 1'b1, '{16'hFFFF, 1'b0, 7'd0, 1'b1}},
    '{nrsc_pkg::FUNC_RECORD, 16'h0000, 2'd2, 16'hFFFF, 1'b0, '0},
    '{nrsc_pkg::FUNC_RECORD, 16'hFFFF, 2'd2, 16'h0000, 1'b0, '0},
    '{nrsc_pkg::FUNC_RECORD, 16'h1234, 2'd0, 16'h0000, 1'b0, '0},
    '{nrsc_pkg::FUNC_RECORD, 16'h1234, 2'd1, 16'h0000, 1'b0, '0},
    '{nrsc_pkg::FUNC_RECORD, 16'h1234, 2'd3, 16'h0000, 1'b0, '0},
    '{nrsc_pkg::FUNC_RECORD, 16'h1234, 2'd2, 16'h0000, 1'b0, '0},
    '{nrsc_pkg::FUNC_NACK,   16'h0000, 2'd2, 16'h0000, 1'b1, '{16'h0000, 1'b1, 7'd0, 1'b1}},
    '{nrsc_pkg::FUNC_NACK,   16'h1234, 2'd1, 16'h0000, 1'b1, '{16'h1234, 1'b1, 7'd2, 1'b1}},
    '{nrsc_pkg::FUNC_NACK,   16'hFFFE, 2'd0, 16'hFFFF, 1'b0, '0},
    '{nrsc_pkg::FUNC_RECORD, 16'h0000, 2'd2, 16'h0000, 1'b0, '0},
    '{nrsc_pkg::FUNC_NACK,   16'h0000, 2'd3, 16'h8001, 1'b0, '0},
    '{nrsc_pkg::FUNC_NACK,   16'hFFFF, 2'd0, 16'h0001, 1'b0, '0},
    '{nrsc_pkg::FUNC_NACK,   16'h4321, 2'd0, 16'h0000, 1'b1, '{16'h4321, 1'b0, 7'd0, 1'b1}},
    '{nrsc_pkg::FUNC_NACK,   16'h1233, 2'd2, 16'h8000, 1'b0, '0},
    '{nrsc_pkg::FUNC_RECORD, 16'hAAAA, 2'd2, 16'h5555, 1'b0, '0},
    '{nrsc_pkg::FUNC_RECORD, 16'h5555, 2'd2, 16'hAAAA, 1'b0, '0},
    '{nrsc_pkg::FUNC_NACK,   16'h5555, 2'd1, 16'hAAAA, 1'b0, '0},
    '{nrsc_pkg::FUNC_NACK,   16'hAAAA, 2'd3, 16'h5555, 1'b0, '0},
    '{nrsc_pkg::FUNC_NACK,   16'h0001, 2'd0, 16'h0000, 1'b1, '{16'h0001, 1'b0, 7'd0, 1'b1}}
  };

  nack_retransmit_seq_cache_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_seq_num     (in_seq_num),
    .in_rtp_version (in_rtp_version),
    .in_lost_mask   (in_lost_mask),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_req_seq    (out_req_seq),
    .out_found      (out_found),
    .out_slot       (out_slot),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned keep_cap();
    int unsigned cap;
    cap = keep_limit;
    if (cap == 0) cap = 1;
    if (cap > nrsc_pkg::CACHE_DEPTH) cap = nrsc_pkg::CACHE_DEPTH;
    return cap;
  endfunction

  function automatic void cache_record(logic [nrsc_pkg::SEQ_W-1:0] seq,
                                       logic [nrsc_pkg::VER_W-1:0] ver);
    if (ver != nrsc_pkg::STORED_VERSION) return;
    // full (or limit lowered): drop the oldest, so the count never shrinks
    if (held_count >= keep_cap()) begin
      oldest_slot = (oldest_slot + 1) % nrsc_pkg::CACHE_DEPTH;
      held_count--;
    end
    sent_seqs[(oldest_slot + held_count) % nrsc_pkg::CACHE_DEPTH] = seq;
    held_count++;
  endfunction

  function automatic lookup_t cache_lookup(logic [nrsc_pkg::SEQ_W-1:0] seq, logic is_last);
    lookup_t     r;
    int unsigned p;
    r = '{req_seq: seq, found: 1'b0, slot: '0, last: is_last};
    for (int unsigned i = 0; i < held_count; i++) begin
      p = (oldest_slot + i) % nrsc_pkg::CACHE_DEPTH;
      if (sent_seqs[p] == seq) begin
        r.found = 1'b1;
        r.slot  = nrsc_pkg::SLOT_W'(p);
        return r;
      end
    end
    return r;
  endfunction

  function automatic void cache_nack(logic [nrsc_pkg::SEQ_W-1:0] id,
                                     logic [nrsc_pkg::MASK_W-1:0] mask);
    logic [nrsc_pkg::SEQ_W-1:0]  cur;
    logic [nrsc_pkg::MASK_W-1:0] rest;
    lookups_due.push_back(cache_lookup(id, mask == '0));
    cur  = id + 1'b1;
    rest = mask;
    while (rest != '0) begin
      if (rest[0]) lookups_due.push_back(cache_lookup(cur, (rest >> 1) == '0));
      rest = rest >> 1;
      cur  = cur + 1'b1;
    end
  endfunction

  function automatic void model_request(logic func, logic [nrsc_pkg::SEQ_W-1:0] seq,
                                        logic [nrsc_pkg::VER_W-1:0] ver,
                                        logic [nrsc_pkg::MASK_W-1:0] mask);
    if (func == nrsc_pkg::FUNC_NACK) cache_nack(seq, mask);
    else cache_record(seq, ver);
  endfunction

  task automatic flag_mismatch(string what);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // returns at the edge where the request is taken
  task automatic offer_request(logic func, logic [nrsc_pkg::SEQ_W-1:0] seq,
                               logic [nrsc_pkg::VER_W-1:0] ver,
                               logic [nrsc_pkg::MASK_W-1:0] mask);
    in_valid       <= 1'b1;
    in_func        <= func;
    in_seq_num     <= seq;
    in_rtp_version <= ver;
    in_lost_mask   <= mask;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic tx_pause();
    if ($urandom_range(0, 31) == 0) tx_bursty = !tx_bursty;
    if (!quiet_tail && tx_bursty && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // drop valid, wait for every lookup to come back, then let the block settle
  task automatic settle();
    in_valid <= 1'b0;
    while (lookups_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic                        func;
    logic [nrsc_pkg::SEQ_W-1:0]  seq;
    logic [nrsc_pkg::VER_W-1:0]  ver;
    logic [nrsc_pkg::MASK_W-1:0] mask;
    logic [nrsc_pkg::SEQ_W-1:0]  seq_base;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_func        <= nrsc_pkg::FUNC_RECORD;
    in_seq_num     <= '0;
    in_rtp_version <= '0;
    in_lost_mask   <= '0;
    cfg_valid      <= 1'b0;
    cfg_data       <= '0;
    oldest_slot    = 0;
    held_count     = 0;
    keep_limit     = nrsc_pkg::MAX_ENTRIES_RST;
    mismatch_count = 0;
    quiet_tail     = 1'b0;
    tx_bursty      = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].func, directed_rows[i].seq, directed_rows[i].ver,
                    directed_rows[i].mask);
      if (directed_rows[i].typed) lookups_due.push_back(directed_rows[i].want);
      else model_request(directed_rows[i].func, directed_rows[i].seq, directed_rows[i].ver,
                         directed_rows[i].mask);
      tx_pause();
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      cfg_valid <= 1'b1;
      cfg_data  <= nrsc_pkg::CFG_W'(PHASE_LIMIT[ph]);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      keep_limit = nrsc_pkg::CFG_W'(PHASE_LIMIT[ph]);
      cfg_valid <= 1'b0;
      quiet_tail = (ph == NUM_PHASES - 1);
      // one phase sits just below the wrap of the sequence space
      seq_base = (ph == 3) ? 16'hFFF0 : nrsc_pkg::SEQ_W'($urandom());
      for (int n = 0; n < PHASE_ITEMS[ph]; n++) begin
        if ($urandom_range(0, 99) < PHASE_RECORD_PCT[ph]) begin
          func = nrsc_pkg::FUNC_RECORD;
          seq  = ($urandom_range(0, 9) == 0)
                 ? nrsc_pkg::SEQ_W'($urandom())
                 : seq_base + nrsc_pkg::SEQ_W'($urandom_range(0, 47));
          ver  = ($urandom_range(0, 15) == 0) ? nrsc_pkg::VER_W'($urandom())
                                               : nrsc_pkg::STORED_VERSION;
          mask = nrsc_pkg::MASK_W'($urandom());
        end else begin
          func = nrsc_pkg::FUNC_NACK;
          seq  = ($urandom_range(0, 7) == 0)
                 ? nrsc_pkg::SEQ_W'($urandom())
                 : seq_base + nrsc_pkg::SEQ_W'($urandom_range(0, 47));
          ver  = nrsc_pkg::VER_W'($urandom());
          case ($urandom_range(0, 7))
            0:       mask = '0;
            1:       mask = '1;
            2, 3:    mask = nrsc_pkg::MASK_W'($urandom() & $urandom());
            default: mask = nrsc_pkg::MASK_W'($urandom());
          endcase
        end
        offer_request(func, seq, ver, mask);
        model_request(func, seq, ver, mask);
        tx_pause();
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // result receiver, with one long hold-off so the block backs up into its input
  initial begin
    bit calm;
    bit long_hold_done;
    calm           = 1'b0;
    long_hold_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 47) == 0) calm = !calm;
      if (!long_hold_done && results_checked >= LONG_HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet_tail && !calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial results_checked = 0;

  always @(posedge clk) begin
    lookup_t want;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (lookups_due.size() == 0) begin
        flag_mismatch($sformatf("result for seq %h with nothing pending", out_req_seq));
      end else begin
        want = lookups_due.pop_front();
        if (out_req_seq !== want.req_seq)
          flag_mismatch($sformatf("req_seq %h, want %h", out_req_seq, want.req_seq));
        if (out_found !== want.found)
          flag_mismatch($sformatf("seq %h found %b, want %b", want.req_seq, out_found,
                                  want.found));
        if (out_slot !== want.slot)
          flag_mismatch($sformatf("seq %h slot %0d, want %0d", want.req_seq, out_slot,
                                  want.slot));
        if (out_last !== want.last)
          flag_mismatch($sformatf("seq %h last %b, want %b", want.req_seq, out_last,
                                  want.last));
      end
    end
  end

  initial idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule

/* sim.f */
rtl/core/nrsc_pkg.sv
rtl/core/nrsc_ctrl.sv
rtl/core/nrsc_dp.sv
rtl/core/nack_retransmit_seq_cache_core.sv
tb/nack_retransmit_seq_cache_core_tb.sv
